// ===== design/fat_directory_entry_scanner_defines.svh =====
// ---------------------------------------------------------------------------
// FAT directory entry scanner assertion macros
// Shared concurrent assertion wrappers for the scanner checker.
// ---------------------------------------------------------------------------
`ifndef FAT_DIRECTORY_ENTRY_SCANNER_DEFINES_SVH
`define FAT_DIRECTORY_ENTRY_SCANNER_DEFINES_SVH

// check on every rising edge outside reset
`define FDES_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check on every rising edge, reset included
`define FDES_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/fdes_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fdes_pkg
// Types, codes and helpers shared by the FAT directory entry scanner.
// ---------------------------------------------------------------------------
package fdes_pkg;

	localparam int NAME_CHARS = 12;
	localparam int BASE_CHARS = 8;
	localparam int EXT_CHARS = 3;
	localparam int LEN_W = 4;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [7:0] BYTE_END = 8'h00;
	localparam logic [7:0] BYTE_DELETED = 8'hE5;
	localparam logic [7:0] ATTR_LONG_NAME = 8'h0F;
	localparam logic [7:0] ATTR_DIRECTORY = 8'h10;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DOT = 8'h2E;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'd32;
	localparam logic [LEN_W-1:0] MAX_NAME_LEN = LEN_W'(NAME_CHARS);

	typedef enum logic [2:0] {
		ST_SKIPPED = 3'd0,
		ST_COUNTED = 3'd1,
		ST_HIT     = 3'd2,
		ST_END     = 3'd3,
		ST_IGNORED = 3'd4
	} status_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SCAN_MODE        = 3'd0,
		REG_TARGET_INDEX     = 3'd1,
		REG_TARGET_NAME_LOW  = 3'd2,
		REG_TARGET_NAME_HIGH = 3'd3,
		REG_TARGET_LENGTH    = 3'd4
	} cfg_reg_t;

	typedef logic [NAME_CHARS-1:0][7:0] name_t;

	typedef struct packed {
		name_t            chars;
		logic [LEN_W-1:0] len;
	} render_t;

	function automatic logic [7:0] fold_lower(input logic [7:0] c);
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			return c + CASE_OFFSET;
		end
		return c;
	endfunction

endpackage

// ===== design/fat_directory_entry_scanner.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fat_directory_entry_scanner
// Scans 32-byte FAT directory entries for a name or an entry index.
// ---------------------------------------------------------------------------
// Entries arrive on the entry channel (entry_valid / entry_ready), one
// transaction per entry; first_of_scan opens a new scan. Every entry yields
// exactly one result transaction on the result channel (result_valid /
// result_ready) with a status code; counted and hit entries also carry the
// rendered lower-case short name, cluster, size and directory flag.
// Configuration is written through cfg_write / cfg_index / cfg_data, and the
// user must write it only while no transaction is in flight; the block
// does not enforce this. Indexes past the register list are dropped.
// An accepted entry is registered, then evaluated against the scan counter
// and loaded into the result register.
// Throughput: one entry per cycle unless the receiver stalls; the scan
// counter and done flag are updated as each entry leaves the evaluation stage.
// Reset clears configuration, counter, done flag and both valid flags.
// When the receiver stalls, the result register holds, the input stage
// holds its entry behind it, and entry_ready drops once both are full.
// ---------------------------------------------------------------------------
module fat_directory_entry_scanner #(
	parameter int INDEX_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [fdes_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [fdes_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  entry_valid,
	output logic                                  entry_ready,
	input  logic                                  first_of_scan,
	input  logic [63:0]                           name_base,
	input  logic [23:0]                           name_ext,
	input  logic [7:0]                            attr_byte,
	input  logic [15:0]                           cluster_upper,
	input  logic [15:0]                           cluster_lower,
	input  logic [31:0]                           file_size,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output fdes_pkg::status_t                     status,
	output logic [31:0]                           start_cluster,
	output logic [31:0]                           size_out,
	output logic                                  is_directory,
	output logic [63:0]                           rendered_low,
	output logic [31:0]                           rendered_high,
	output logic [fdes_pkg::LEN_W-1:0]            rendered_length,
	output logic [15:0]                           entry_number
);
	import fdes_pkg::*;

	localparam int EW = (INDEX_WIDTH < 16) ? INDEX_WIDTH : 16;

	logic                   scan_mode_q;
	logic [15:0]            target_index_q;
	logic [63:0]            target_low_q;
	logic [31:0]            target_high_q;
	logic [LEN_W-1:0]       target_len_q;

	logic [INDEX_WIDTH-1:0] count_q;
	logic                   finished_q;

	logic                   valid_s1;
	logic                   first_s1;
	logic [63:0]            base_s1;
	logic [23:0]            ext_s1;
	logic [7:0]             attr_s1;
	logic [31:0]            cluster_s1;
	logic [31:0]            size_s1;

	logic                   result_valid_q;
	status_t                status_q;
	logic [31:0]            cluster_q;
	logic [31:0]            size_q;
	logic                   dir_q;
	name_t                  name_q;
	logic [LEN_W-1:0]       len_q;
	logic [15:0]            number_q;

	render_t                rendered;
	name_t                  target_chars;
	logic                   advance;
	logic                   fin;
	logic [INDEX_WIDTH-1:0] cnt;
	logic [INDEX_WIDTH-1:0] target_cmp;
	logic                   name_hit;
	logic                   hit;
	status_t                status_d;

	fdes_render u_render (
		.name_base (base_s1),
		.name_ext  (ext_s1),
		.attr_byte (attr_s1),
		.rendered  (rendered)
	);

	assign advance     = !result_valid_q || result_ready;
	assign entry_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_mode_q    <= 1'b0;
			target_index_q <= '0;
			target_low_q   <= '0;
			target_high_q  <= '0;
			target_len_q   <= '0;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_SCAN_MODE:        scan_mode_q    <= cfg_data[0];
				REG_TARGET_INDEX:     target_index_q <= cfg_data[15:0];
				REG_TARGET_NAME_LOW:  target_low_q   <= cfg_data;
				REG_TARGET_NAME_HIGH: target_high_q  <= cfg_data[31:0];
				REG_TARGET_LENGTH:    target_len_q   <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (entry_ready) begin
			valid_s1 <= entry_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (entry_valid && entry_ready) begin
			first_s1   <= first_of_scan;
			base_s1    <= name_base;
			ext_s1     <= name_ext;
			attr_s1    <= attr_byte;
			cluster_s1 <= {cluster_upper, cluster_lower};
			size_s1    <= file_size;
		end
	end

	assign fin          = first_s1 ? 1'b0 : finished_q;
	assign cnt          = first_s1 ? '0 : count_q;
	assign target_cmp   = INDEX_WIDTH'(target_index_q[EW-1:0]);
	assign target_chars = name_t'({target_high_q, target_low_q});

	always_comb begin
		name_hit = (target_len_q <= MAX_NAME_LEN) && (target_len_q == rendered.len);
		for (int k = 0; k < NAME_CHARS; k++) begin
			if (LEN_W'(k) < rendered.len &&
			    fold_lower(target_chars[k]) != rendered.chars[k]) begin
				name_hit = 1'b0;
			end
		end
		hit = scan_mode_q ? (cnt == target_cmp) : name_hit;
	end

	always_comb begin
		if (fin) begin
			status_d = ST_IGNORED;
		end else if (base_s1[7:0] == BYTE_END) begin
			status_d = ST_END;
		end else if (base_s1[7:0] == BYTE_DELETED || attr_s1 == ATTR_LONG_NAME) begin
			status_d = ST_SKIPPED;
		end else if (hit) begin
			status_d = ST_HIT;
		end else begin
			status_d = ST_COUNTED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			count_q        <= '0;
			finished_q     <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
			if (valid_s1) begin
				count_q    <= (status_d == ST_COUNTED) ? cnt + INDEX_WIDTH'(1) : cnt;
				finished_q <= fin || status_d == ST_END || status_d == ST_HIT;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			status_q <= status_d;
			if (status_d == ST_HIT || status_d == ST_COUNTED) begin
				cluster_q <= cluster_s1;
				size_q    <= size_s1;
				dir_q     <= |(attr_s1 & ATTR_DIRECTORY);
				name_q    <= rendered.chars;
				len_q     <= rendered.len;
				number_q  <= 16'(cnt[EW-1:0]);
			end else begin
				cluster_q <= '0;
				size_q    <= '0;
				dir_q     <= 1'b0;
				name_q    <= '0;
				len_q     <= '0;
				number_q  <= '0;
			end
		end
	end

	assign result_valid    = result_valid_q;
	assign status          = status_q;
	assign start_cluster   = cluster_q;
	assign size_out        = size_q;
	assign is_directory    = dir_q;
	assign rendered_low    = name_q[BASE_CHARS-1:0];
	assign rendered_high   = name_q[NAME_CHARS-1:BASE_CHARS];
	assign rendered_length = len_q;
	assign entry_number    = number_q;

endmodule

// ===== design/fdes_render.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fdes_render
// Renders a raw short directory entry name (base and extension) as a
// lower-case name, with a dot before the extension when one is shown.
// ---------------------------------------------------------------------------
module fdes_render (
	input  logic [63:0]        name_base,
	input  logic [23:0]        name_ext,
	input  logic [7:0]         attr_byte,
	output fdes_pkg::render_t  rendered
);
	import fdes_pkg::*;

	logic [7:0]       raw [NAME_CHARS];
	logic [7:0]       ext_raw [4];
	logic [LEN_W-1:0] base_len;
	logic [LEN_W-1:0] ext_len;
	logic             ext_on;

	always_comb begin
		for (int k = 0; k < NAME_CHARS; k++) begin
			if (k < BASE_CHARS) begin
				raw[k] = name_base[8*k +: 8];
			end else if (k < BASE_CHARS + EXT_CHARS) begin
				raw[k] = name_ext[8*(k-BASE_CHARS) +: 8];
			end else begin
				raw[k] = BYTE_END;
			end
		end
		for (int k = 0; k < 4; k++) begin
			ext_raw[k] = (k < EXT_CHARS) ? raw[BASE_CHARS+k] : BYTE_END;
		end
	end

	always_comb begin
		base_len = LEN_W'(BASE_CHARS);
		for (int k = BASE_CHARS - 1; k >= 0; k--) begin
			if (raw[k] == CHAR_SPACE) begin
				base_len = LEN_W'(k);
			end
		end
		ext_len = LEN_W'(EXT_CHARS);
		for (int k = EXT_CHARS - 1; k >= 0; k--) begin
			if (ext_raw[k] == CHAR_SPACE) begin
				ext_len = LEN_W'(k);
			end
		end
		ext_on = (attr_byte != ATTR_DIRECTORY) && (ext_raw[0] != CHAR_SPACE);
	end

	always_comb begin
		logic [LEN_W-1:0] off;
		for (int p = 0; p < NAME_CHARS; p++) begin
			off = LEN_W'(p) - base_len - LEN_W'(1);
			if (LEN_W'(p) < base_len) begin
				rendered.chars[p] = fold_lower(raw[p]);
			end else if (ext_on && LEN_W'(p) == base_len) begin
				rendered.chars[p] = CHAR_DOT;
			end else if (ext_on && LEN_W'(p) > base_len && off < ext_len) begin
				rendered.chars[p] = fold_lower(ext_raw[off[1:0]]);
			end else begin
				rendered.chars[p] = BYTE_END;
			end
		end
		rendered.len = base_len + (ext_on ? (LEN_W'(1) + ext_len) : LEN_W'(0));
	end

endmodule

// ===== design/fdes_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fdes_checker
// Port-level checks on the result channel of the directory entry scanner.
// ---------------------------------------------------------------------------
`include "fat_directory_entry_scanner_defines.svh"

module fdes_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       result_valid,
	input  logic                       result_ready,
	input  fdes_pkg::status_t          status,
	input  logic [31:0]                start_cluster,
	input  logic [31:0]                size_out,
	input  logic [63:0]                rendered_low,
	input  logic [31:0]                rendered_high,
	input  logic [fdes_pkg::LEN_W-1:0] rendered_length,
	input  logic [15:0]                entry_number
);
	import fdes_pkg::*;

	`FDES_ASSERT_ALWAYS(a_no_result_in_reset, !arst_n |=> !result_valid, "result valid in reset")

	`FDES_ASSERT(a_stall_holds, result_valid && !result_ready |=> result_valid && $stable(status) && $stable(start_cluster) && $stable(rendered_low), "stalled result changed")

	`FDES_ASSERT(a_idle_fields_zero, result_valid && (status == ST_SKIPPED || status == ST_END || status == ST_IGNORED) |-> start_cluster == 0 && size_out == 0 && rendered_low == 0 && rendered_length == 0 && entry_number == 0, "uncounted result carries data")

	`FDES_ASSERT(a_length_range, result_valid |-> rendered_length <= MAX_NAME_LEN && status <= ST_IGNORED, "result length or status out of range")

	`FDES_ASSERT(a_short_name_high_clear, result_valid && rendered_length <= 4'd8 |-> rendered_high == 0, "characters past the name length")

endmodule

bind fat_directory_entry_scanner fdes_checker u_fdes_checker (.*);
